// ----- src/smae_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smae_pkg
// Shared constants, types and helpers of the sparse matrix assembly engine.
// ----------------------------------------------------------------------------
package smae_pkg;

	localparam int MAX_EQUATIONS = 64;
	localparam int MAX_ENTRIES   = 1024;
	localparam int VALUE_WIDTH   = 48;

	localparam int ROW_W  = $clog2(MAX_EQUATIONS);
	localparam int NEQ_W  = $clog2(MAX_EQUATIONS + 1);
	localparam int ENT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W = $clog2(MAX_ENTRIES);
	localparam int OP_W   = 2;
	localparam int STS_W  = 3;

	// pattern store word: {row mask, row start}
	localparam int PAT_W = MAX_EQUATIONS + ENT_W;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = NEQ_W;

	// queue depth kept a power of two so the pointers wrap by themselves
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYMMETRIC_MODE = 1'b0,
		CFG_NUM_EQUATIONS  = 1'b1
	} cfg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_CLEAR = 2'd1,
		OP_ADD   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		K_LOAD,
		K_CLEAR,
		K_ADD,
		K_BAD
	} kind_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK             = 3'd0,
		STS_NOT_READY      = 3'd1,
		STS_EMPTY_ROW      = 3'd2,
		STS_ENTRY_MISSING  = 3'd3,
		STS_MIRROR_MISSING = 3'd4,
		STS_CAPACITY       = 3'd5,
		STS_EXTRA_ROW      = 3'd6,
		STS_SATURATED      = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		BE_IDLE,
		BE_SWEEP,
		BE_LOCATE,
		BE_ACCUM
	} be_state_t;

	// classified command, front to back
	typedef struct packed {
		kind_t                    kind;
		logic                     in_range;
		logic [ROW_W-1:0]         row;
		logic [ROW_W-1:0]         col;
		logic [VALUE_WIDTH-1:0]   amount;
		logic [MAX_EQUATIONS-1:0] mask;
		logic [NEQ_W-1:0]         mask_cnt;
		logic [NEQ_W-1:0]         n;
	} cmd_t;

	localparam int NLANE = (MAX_EQUATIONS + 7) / 8;

	// byte-lane population count
	function automatic logic [NEQ_W-1:0] popcount(input logic [MAX_EQUATIONS-1:0] v);
		logic [NLANE*8-1:0] pv;
		logic [3:0]         lane;
		logic [NEQ_W-1:0]   total;
		pv    = (NLANE*8)'(v);
		total = '0;
		for (int l = 0; l < NLANE; l++) begin
			lane = '0;
			for (int b = 0; b < 8; b++) begin
				lane = lane + 4'(pv[l*8+b]);
			end
			total = total + NEQ_W'(lane);
		end
		return total;
	endfunction

endpackage
`default_nettype wire

// ----- src/smae_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smae_in_if / smae_out_if
// Valid/ready channels carrying command and result transactions.
// ----------------------------------------------------------------------------
interface smae_in_if;
	logic                                       valid;
	logic                                       ready;
	logic [smae_pkg::OP_W-1:0]                  op;
	logic [smae_pkg::ROW_W-1:0]                 row;
	logic [smae_pkg::ROW_W-1:0]                 col;
	logic signed [smae_pkg::VALUE_WIDTH-1:0]    amount;
	logic [smae_pkg::MAX_EQUATIONS-1:0]         pattern_bits;

	modport source(output valid, op, row, col, amount, pattern_bits, input ready);
	modport sink(input valid, op, row, col, amount, pattern_bits, output ready);
endinterface

interface smae_out_if;
	logic                                       valid;
	logic                                       ready;
	logic [smae_pkg::STS_W-1:0]                 status;
	logic signed [smae_pkg::VALUE_WIDTH-1:0]    value_after;
	logic signed [smae_pkg::VALUE_WIDTH-1:0]    mirror_value_after;
	logic [smae_pkg::ENT_W-1:0]                 entries_used;

	modport source(output valid, status, value_after, mirror_value_after, entries_used,
		input ready);
	modport sink(input valid, status, value_after, mirror_value_after, entries_used,
		output ready);
endinterface
`default_nettype wire

// ----- src/smae_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smae_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- src/smae_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smae_front
// Accepts command transactions, clamps the order and classifies each item.
// ----------------------------------------------------------------------------
module smae_front (
	smae_in_if.sink                           in_ch,
	input  wire logic [smae_pkg::NEQ_W-1:0]   num_eq,
	input  wire logic                         accept_en,
	input  wire logic                         q_full,
	output logic                              q_push,
	output smae_pkg::cmd_t                    q_data
);
	import smae_pkg::*;

	logic [NEQ_W-1:0]         n;
	logic [MAX_EQUATIONS-1:0] colmask;
	logic [MAX_EQUATIONS-1:0] mask;

	always_comb begin
		if (num_eq == '0) begin
			n = NEQ_W'(1);
		end else if (num_eq > NEQ_W'(MAX_EQUATIONS)) begin
			n = NEQ_W'(MAX_EQUATIONS);
		end else begin
			n = num_eq;
		end
	end

	// a shift by the full width leaves zero, so n == MAX_EQUATIONS gives all ones
	assign colmask = ~({MAX_EQUATIONS{1'b1}} << n);
	assign mask    = in_ch.pattern_bits & colmask;

	always_comb begin
		case (in_ch.op)
			OP_LOAD:  q_data.kind = K_LOAD;
			OP_CLEAR: q_data.kind = K_CLEAR;
			OP_ADD:   q_data.kind = K_ADD;
			default:  q_data.kind = K_BAD;
		endcase
		q_data.in_range = (NEQ_W'(in_ch.row) < n) && (NEQ_W'(in_ch.col) < n);
		q_data.row      = in_ch.row;
		q_data.col      = in_ch.col;
		q_data.amount   = in_ch.amount;
		q_data.mask     = mask;
		q_data.mask_cnt = popcount(mask);
		q_data.n        = n;
	end

	assign in_ch.ready = accept_en && !q_full;
	assign q_push      = in_ch.valid && in_ch.ready;

endmodule
`default_nettype wire

// ----- src/smae_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smae_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module smae_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire smae_pkg::cmd_t  push_data,
	input  wire logic            pop,
	output logic                 full,
	output logic                 empty,
	output smae_pkg::cmd_t       head
);
	import smae_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// ----- src/smae_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smae_back
// Executes commands against the pattern and value stores, builds results.
// ----------------------------------------------------------------------------
module smae_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            symmetric,
	input  wire logic            q_empty,
	input  wire smae_pkg::cmd_t  q_head,
	output logic                 q_pop,
	output logic                 accept_en,
	smae_out_if.source           out_ch
);
	import smae_pkg::*;

	localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	be_state_t state_q, state_nx;

	cmd_t                   cmd_q;
	logic                   mirror_q;
	logic                   init_q;
	logic [ADDR_W-1:0]      sweep_q;
	logic [NEQ_W-1:0]       rows_loaded_q;
	logic [ENT_W-1:0]       used_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [VALUE_WIDTH-1:0] vafter_q;
	logic                   sat_q;

	logic                   out_valid_q;
	status_t                out_status_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [VALUE_WIDTH-1:0] out_mirror_q;
	logic [ENT_W-1:0]       out_entries_q;

	// store ports
	logic                   pat_we;
	logic [ROW_W-1:0]       pat_waddr;
	logic [PAT_W-1:0]       pat_wdata;
	logic [ROW_W-1:0]       pat_raddr;
	logic [PAT_W-1:0]       pat_rdata;
	logic                   val_we;
	logic [ADDR_W-1:0]      val_waddr;
	logic [VALUE_WIDTH-1:0] val_wdata;
	logic [ADDR_W-1:0]      val_raddr;
	logic [VALUE_WIDTH-1:0] val_rdata;

	// datapath
	logic                   start;
	logic                   sweep_end;
	logic [ENT_W:0]         ld_total;
	logic                   ld_extra;
	logic                   ld_cap;
	logic                   add_go;
	logic [ROW_W-1:0]       cur_r;
	logic [ROW_W-1:0]       cur_c;
	logic [MAX_EQUATIONS-1:0] pmask;
	logic [ENT_W-1:0]       pstart;
	logic                   hit;
	logic [ENT_W-1:0]       loc;
	logic [VALUE_WIDTH:0]   sum;
	logic                   ovf;
	logic [VALUE_WIDTH-1:0] newv;
	logic                   go_mirror;

	// controls
	logic                   fin;
	status_t                fin_status;
	logic [VALUE_WIDTH-1:0] fin_value;
	logic [VALUE_WIDTH-1:0] fin_mirror;

	smae_ram #(.WIDTH(PAT_W), .DEPTH(MAX_EQUATIONS)) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (pat_wdata),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	smae_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	assign start     = (state_q == BE_IDLE) && !q_empty && !out_valid_q;
	assign sweep_end = (sweep_q == ADDR_W'(MAX_ENTRIES - 1));
	assign accept_en = !init_q;

	assign ld_total = (ENT_W+1)'(used_q) + (ENT_W+1)'(q_head.mask_cnt);
	assign ld_extra = (rows_loaded_q >= q_head.n);
	assign ld_cap   = (ld_total > (ENT_W+1)'(MAX_ENTRIES));
	assign add_go   = (rows_loaded_q >= q_head.n) && q_head.in_range;

	// locate: entry index is row start plus set mask bits below the column
	assign cur_r  = mirror_q ? cmd_q.col : cmd_q.row;
	assign cur_c  = mirror_q ? cmd_q.row : cmd_q.col;
	assign pmask  = pat_rdata[ENT_W +: MAX_EQUATIONS];
	assign pstart = pat_rdata[ENT_W-1:0];
	assign hit    = pmask[cur_c];
	assign loc    = pstart + ENT_W'(popcount(pmask & ~({MAX_EQUATIONS{1'b1}} << cur_c)));

	// saturating accumulate
	assign sum  = {val_rdata[VALUE_WIDTH-1], val_rdata}
		+ {cmd_q.amount[VALUE_WIDTH-1], cmd_q.amount};
	assign ovf  = (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]);
	assign newv = ovf ? (sum[VALUE_WIDTH] ? VAL_MIN : VAL_MAX) : sum[VALUE_WIDTH-1:0];
	assign go_mirror = !mirror_q && symmetric && (cmd_q.row != cmd_q.col);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BE_IDLE: begin
				if (start) begin
					case (q_head.kind)
						K_CLEAR: state_nx = BE_SWEEP;
						K_ADD:   state_nx = add_go ? BE_LOCATE : BE_IDLE;
						default: state_nx = BE_IDLE;
					endcase
				end
			end
			BE_SWEEP: begin
				if (sweep_end) begin
					state_nx = BE_IDLE;
				end
			end
			BE_LOCATE: begin
				state_nx = hit ? BE_ACCUM : BE_IDLE;
			end
			BE_ACCUM: begin
				state_nx = go_mirror ? BE_LOCATE : BE_IDLE;
			end
			default: state_nx = BE_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop      = 1'b0;
		pat_we     = 1'b0;
		pat_waddr  = rows_loaded_q[ROW_W-1:0];
		pat_wdata  = {q_head.mask, used_q};
		pat_raddr  = q_head.row;
		val_we     = 1'b0;
		val_waddr  = addr_q;
		val_wdata  = newv;
		val_raddr  = loc[ADDR_W-1:0];
		fin        = 1'b0;
		fin_status = STS_OK;
		fin_value  = '0;
		fin_mirror = '0;
		case (state_q)
			BE_IDLE: begin
				q_pop = start;
				if (start) begin
					case (q_head.kind)
						K_LOAD: begin
							fin = 1'b1;
							if (ld_extra) begin
								fin_status = STS_EXTRA_ROW;
							end else if (ld_cap) begin
								fin_status = STS_CAPACITY;
							end else begin
								pat_we = 1'b1;
							end
						end
						K_ADD: begin
							if (!add_go) begin
								fin        = 1'b1;
								fin_status = STS_NOT_READY;
							end
						end
						K_CLEAR: begin
						end
						default: begin
							fin        = 1'b1;
							fin_status = STS_NOT_READY;
						end
					endcase
				end
			end
			BE_SWEEP: begin
				val_we    = 1'b1;
				val_waddr = sweep_q;
				val_wdata = '0;
				fin       = sweep_end && !init_q;
			end
			BE_LOCATE: begin
				if (!hit) begin
					fin = 1'b1;
					if (mirror_q) begin
						fin_status = STS_MIRROR_MISSING;
						fin_value  = vafter_q;
					end else if (pmask == '0) begin
						fin_status = STS_EMPTY_ROW;
					end else begin
						fin_status = STS_ENTRY_MISSING;
					end
				end
			end
			BE_ACCUM: begin
				val_we    = 1'b1;
				pat_raddr = cmd_q.col;
				if (!go_mirror) begin
					fin        = 1'b1;
					fin_status = (ovf || (mirror_q && sat_q)) ? STS_SATURATED : STS_OK;
					fin_value  = mirror_q ? vafter_q : newv;
					fin_mirror = mirror_q ? newv : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BE_SWEEP;
			init_q        <= 1'b1;
			sweep_q       <= '0;
			mirror_q      <= 1'b0;
			rows_loaded_q <= '0;
			used_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == BE_SWEEP) begin
				sweep_q <= sweep_end ? '0 : sweep_q + ADDR_W'(1);
				if (sweep_end) begin
					init_q <= 1'b0;
				end
			end
			if (q_pop) begin
				mirror_q <= 1'b0;
			end else if (state_q == BE_ACCUM && go_mirror) begin
				mirror_q <= 1'b1;
			end
			if (pat_we) begin
				rows_loaded_q <= rows_loaded_q + NEQ_W'(1);
				used_q        <= ld_total[ENT_W-1:0];
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (state_q == BE_LOCATE) begin
			addr_q <= loc[ADDR_W-1:0];
		end
		if (state_q == BE_ACCUM && go_mirror) begin
			vafter_q <= newv;
			sat_q    <= ovf;
		end
		if (fin) begin
			out_status_q  <= fin_status;
			out_value_q   <= fin_value;
			out_mirror_q  <= fin_mirror;
			out_entries_q <= pat_we ? ld_total[ENT_W-1:0] : used_q;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.status             = out_status_q;
	assign out_ch.value_after        = out_value_q;
	assign out_ch.mirror_value_after = out_mirror_q;
	assign out_ch.entries_used       = out_entries_q;

`ifndef SYNTHESIS
	a_fin_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !out_valid_q)
		else $error("result produced while output register still full");

	a_val_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		val_we |-> (state_q == BE_SWEEP || state_q == BE_ACCUM))
		else $error("value store written outside sweep or accumulate");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= ENT_W'(MAX_ENTRIES))
		else $error("entry count beyond capacity");

	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_loaded_q <= NEQ_W'(MAX_EQUATIONS))
		else $error("loaded row count beyond order");

	a_pop_progress: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q != BE_IDLE) || out_valid_q)
		else $error("popped command neither executing nor finished");
`endif

endmodule
`default_nettype wire

// ----- src/sparse_matrix_assembly_engine_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_matrix_assembly_engine_unit
// Compressed sparse row assembly store: pattern load, clear, saturating add.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      op, row, col, amount, pattern_bits
// out_ch    out  valid/ready      status, value_after, mirror_value_after,
//                                 entries_used
// cfg       in   cfg_we           cfg_index, cfg_wdata
//
// Back end: loads and items rejected on arrival finish in the idle state; an add
// does a pattern read, a value read and a value write, a mirrored add repeats
// them for the mirror entry, and a clear zeroes every entry through the value
// store's single write port. After reset a sweep zeroes the value store;
// in_ch.ready is low meanwhile. Items queue two deep ahead of the back end; a
// new item starts only once the previous result has been taken from out_ch.
// ----------------------------------------------------------------------------
module sparse_matrix_assembly_engine_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	smae_in_if.sink                                in_ch,
	smae_out_if.source                             out_ch,
	input  wire logic                              cfg_we,
	input  wire logic [smae_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [smae_pkg::CFG_W-1:0]        cfg_wdata
);
	import smae_pkg::*;

	logic             sym_q;
	logic [NEQ_W-1:0] num_eq_q;

	logic accept_en;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t q_data;
	cmd_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q    <= 1'b0;
			num_eq_q <= NEQ_W'(MAX_EQUATIONS);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYMMETRIC_MODE: sym_q    <= cfg_wdata[0];
				CFG_NUM_EQUATIONS:  num_eq_q <= cfg_wdata[NEQ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	smae_front u_front (
		.in_ch     (in_ch),
		.num_eq    (num_eq_q),
		.accept_en (accept_en),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	smae_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	smae_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.symmetric (sym_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.accept_en (accept_en),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire
